// ===== sv/lspq_pkg.sv =====
// Shared constants, types and helpers for the linear-scan priority queue.
`timescale 1ns / 1ps

package lspq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(QUEUE_DEPTH);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   mode;
    entry_t entry;
  } item_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    entry_t              entry;
  } result_t;

  // Ring-buffer slot arithmetic: base + off, wrapped to the depth (off < depth).
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/lspq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module lspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/lspq_seq.sv =====
// Sequencer: ring pointers, scan and shift passes over the entry memory.
`timescale 1ns / 1ps

module lspq_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  lspq_pkg::item_t           req,
  output logic                      idle,
  output lspq_pkg::result_t         res,
  input  logic                      res_take,
  output lspq_pkg::mem_req_t        mem_req,
  input  lspq_pkg::entry_t          mem_rd_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t                             state;
  logic [lspq_pkg::IDX_W-1:0]         head;
  logic [lspq_pkg::IDX_W-1:0]         tail;
  logic [lspq_pkg::CNT_W-1:0]         count;
  logic [lspq_pkg::CNT_W-1:0]         rd_off;
  logic [lspq_pkg::CNT_W-1:0]         pend_off;
  logic                               pend_valid;
  lspq_pkg::entry_t                   best;
  logic [lspq_pkg::CNT_W-1:0]         best_off;
  logic [lspq_pkg::STATUS_W-1:0]      res_status;
  lspq_pkg::entry_t                   res_entry;

  logic                               issue;
  logic                               last;
  logic                               take;
  logic [lspq_pkg::CNT_W-1:0]         sel_off;
  lspq_pkg::entry_t                   sel_entry;
  logic [lspq_pkg::CNT_W-1:0]         wr_off;
  logic                               full;

  assign full      = (count == lspq_pkg::DEPTH_CNT);
  assign issue     = (state == ST_SCAN || state == ST_SHIFT) && (rd_off < count);
  assign last      = pend_valid && (pend_off == count - lspq_pkg::CNT_W'(1));
  assign take      = (pend_off == '0) || (mem_rd_data.prio < best.prio);
  assign sel_off   = take ? pend_off : best_off;
  assign sel_entry = take ? mem_rd_data : best;
  assign wr_off    = pend_off - lspq_pkg::CNT_W'(1);

  assign idle = (state == ST_IDLE);
  assign res  = '{valid: (state == ST_RESULT), status: res_status, entry: res_entry};

  // Memory requests: push write at the tail, scan and shift reads, shift write-back.
  always_comb begin
    mem_req         = '0;
    mem_req.rd_addr = lspq_pkg::slot_add(head, rd_off[lspq_pkg::IDX_W-1:0]);
    if (state == ST_IDLE) begin
      mem_req.rd_addr = head;
      if (req_valid && req.mode == lspq_pkg::MODE_PUSH && !full) begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tail;
        mem_req.wr_data = req.entry;
      end
    end else if (state == ST_SHIFT && pend_valid) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = lspq_pkg::slot_add(head, wr_off[lspq_pkg::IDX_W-1:0]);
      mem_req.wr_data = mem_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            res_entry <= '0;
            if (req.mode == lspq_pkg::MODE_PUSH) begin
              state <= ST_RESULT;
              if (full) begin
                res_status <= lspq_pkg::STATUS_FULL;
              end else begin
                res_status <= lspq_pkg::STATUS_DONE;
                tail       <= lspq_pkg::slot_add(tail, lspq_pkg::IDX_W'(1));
                count      <= count + lspq_pkg::CNT_W'(1);
              end
            end else if (count == '0) begin
              res_status <= lspq_pkg::STATUS_EMPTY;
              state      <= ST_RESULT;
            end else begin
              rd_off     <= lspq_pkg::CNT_W'(1);
              pend_off   <= '0;
              pend_valid <= 1'b1;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_off     <= rd_off + lspq_pkg::CNT_W'(1);
            pend_off   <= rd_off;
            pend_valid <= 1'b1;
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid && take) begin
            best     <= mem_rd_data;
            best_off <= pend_off;
          end
          if (last) begin
            res_status <= lspq_pkg::STATUS_DONE;
            res_entry  <= sel_entry;
            if (sel_off == '0) begin
              head  <= lspq_pkg::slot_add(head, lspq_pkg::IDX_W'(1));
              count <= count - lspq_pkg::CNT_W'(1);
              state <= ST_RESULT;
            end else if (sel_off + lspq_pkg::CNT_W'(1) == count) begin
              tail  <= lspq_pkg::slot_add(tail, lspq_pkg::IDX_W'(lspq_pkg::QUEUE_DEPTH - 1));
              count <= count - lspq_pkg::CNT_W'(1);
              state <= ST_RESULT;
            end else begin
              rd_off <= sel_off + lspq_pkg::CNT_W'(1);
              state  <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (issue) begin
            rd_off     <= rd_off + lspq_pkg::CNT_W'(1);
            pend_off   <= rd_off;
            pend_valid <= 1'b1;
          end else begin
            pend_valid <= 1'b0;
          end
          if (last) begin
            tail  <= lspq_pkg::slot_add(tail, lspq_pkg::IDX_W'(lspq_pkg::QUEUE_DEPTH - 1));
            count <= count - lspq_pkg::CNT_W'(1);
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/linear_scan_priority_queue_unit.sv =====
// Top level of the linear-scan priority queue: handshakes, result register, entry memory.
`timescale 1ns / 1ps

// Bounded priority queue of 16 payload/priority pairs held as a ring in one
// entry memory (32-bit payload plus 8-bit priority per slot, registered read).
// A request with mode 0 pushes at the tail, or answers status 1 when full;
// mode 1 pops the entry with the smallest priority, the oldest one on a tie,
// or answers status 2 when empty. Every request gives exactly one response;
// data_out and priority_out are zero unless a pop succeeds. One request is
// in work at a time. A push goes from acceptance straight to the result
// state. A pop over n held entries streams the memory read port once to
// find the winner, then, unless the winner is the oldest or the newest
// entry, streams it again to close the gap by moving each later entry one
// slot toward the head, then offers the response. That read port, one
// entry per cycle, sets both passes. The response sits in an output
// register, so a new request is taken while the previous response still
// waits to be collected. The memory needs no clearing after reset: only
// held slots are ever used.

module linear_scan_priority_queue_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic signed [lspq_pkg::DATA_W-1:0]   data_in,
  input  logic        [lspq_pkg::PRIO_W-1:0]   priority_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [lspq_pkg::STATUS_W-1:0] status,
  output logic signed [lspq_pkg::DATA_W-1:0]   data_out,
  output logic        [lspq_pkg::PRIO_W-1:0]   priority_out
);

  lspq_pkg::item_t    req;
  lspq_pkg::result_t  res;
  lspq_pkg::mem_req_t mem_req;
  lspq_pkg::entry_t   mem_rd_data;
  logic               idle;
  logic               res_take;

  // Pack the request fields; the payload is stored as raw bits.
  assign req = '{mode: mode, entry: '{payload: $unsigned(data_in), prio: priority_in}};

  // Take a new request only while the sequencer is idle.
  assign in_ready = idle;

  // The response register is free when empty or being drained this cycle.
  assign res_take = !out_valid || out_ready;

  lspq_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (in_valid),
    .req        (req),
    .idle       (idle),
    .res        (res),
    .res_take   (res_take),
    .mem_req    (mem_req),
    .mem_rd_data(mem_rd_data)
  );

  lspq_ram #(
    .WIDTH($bits(lspq_pkg::entry_t)),
    .DEPTH(lspq_pkg::QUEUE_DEPTH)
  ) u_entries (
    .clk    (clk),
    .wr_en  (mem_req.wr_en),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_data),
    .rd_addr(mem_req.rd_addr),
    .rd_data(mem_rd_data)
  );

  // Output register: load a finished response, hold it until collected.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      status       <= res.status;
      data_out     <= $signed(res.entry.payload);
      priority_out <= res.entry.prio;
    end
  end

  // One request at a time: after an acceptance the block is busy.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one was still in work");

  // A refused request never carries payload or priority.
  a_refused_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lspq_pkg::STATUS_DONE |-> data_out == '0 && priority_out == '0)
    else $error("refused response carries a non-zero payload or priority");

  // Only the three defined status codes are ever offered.
  a_status_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == lspq_pkg::STATUS_DONE || status == lspq_pkg::STATUS_FULL ||
                  status == lspq_pkg::STATUS_EMPTY)
    else $error("undefined status code on the response");

  // A response is loaded only from the result state, which then frees the input.
  a_load_frees_input : assert property (@(posedge clk) disable iff (rst)
    res.valid && res_take |=> in_ready)
    else $error("sequencer did not return to idle after handing over a response");

endmodule
